/* rtl/bsmooth_pkg.sv */
// Shared types and constants for the 3x3 RGB box smoothing core.
// Used by box_smooth_3x3_rgb_core; no dependencies.
`timescale 1ns / 1ps

package bsmooth_pkg;

   localparam int CHAN_W  = 16;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int SUM_W   = 20;
   localparam int CFG_W   = 10;
   localparam int COORD_W = 9;
   localparam int RSP_W   = 72;

   localparam logic [CFG_W-1:0] FRAME_RESET = 10'd512;

   // floor(x / 3) == (x * DIV3_MULT) >> DIV3_SHIFT for x below 2**21
   localparam int              DIV3_SHIFT = 22;
   localparam logic [21:0]     DIV3_MULT  = 22'd1398102;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SUM,
      ST_DIV_ROW,
      ST_DIV_COL
   } state_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } sum_type;

   // divide by a count of 1, 2 or 3
   function automatic logic [SUM_W-1:0] div_small(input logic [SUM_W-1:0] x,
                                                   input logic [1:0] d);
      logic [SUM_W+22-1:0] prod;
      logic [SUM_W-1:0]    q;
      prod = {22'd0, x} * {{SUM_W{1'b0}}, DIV3_MULT};
      case (d)
         2'd2: begin
            q = x >> 1;
         end
         2'd3: begin
            q = prod[DIV3_SHIFT +: SUM_W];
         end
         default: begin
            q = x;
         end
      endcase
      return q;
   endfunction

endpackage

/* rtl/bsmooth_ram.sv */
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bsmooth_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* rtl/box_smooth_3x3_rgb_core.sv */
// 3x3 box smoothing of a square RGB frame; top level.
// Depends on bsmooth_pkg and bsmooth_ram (two line stores in one RAM).
`timescale 1ns / 1ps

// Usage:
//   req_* carries one raster-order pixel per beat. rsp_* carries smoothed
//   pixels tagged with row and column; tlast marks the last result caused by
//   one input pixel. A pixel causes zero to four results, so results along the
//   bottom row and right column leave raster order.
//   csr_we/csr_wdata set the frame size (0 reads as 1, values above MAX_FRAME
//   as MAX_FRAME) and restart the position counters; write only while idle.
// Timing:
//   One pixel at a time. A pixel is accepted while the line RAM is read, then
//   the column entry is read-modify-written and the window shifted; each
//   result then takes a window sum, a divide by row count and a divide by
//   column count. Each divide step uses its own multiply-based divide-by-three
//   per color. A pixel's first result is registered at the output after the
//   fetch, sum and both divide steps.
// Reset:
//   Counters clear, frame size returns to 512, no result pending. The line
//   RAM is not cleared; entries not yet written never reach a result.
// Stall:
//   The output register holds a result until taken; the core waits in the
//   last divide step while the register is full and not being drained.

module box_smooth_3x3_rgb_core #(
   parameter int MAX_FRAME = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bsmooth_pkg::CFG_W-1:0]   csr_wdata,   // frame_size
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bsmooth_pkg::PIX_W-1:0]   req_tdata,   // red_in, green_in, blue_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bsmooth_pkg::RSP_W-1:0]   rsp_tdata,   // out_row, out_col, red_out,
                                                        // green_out, blue_out, zero pad
   output logic                            rsp_tlast    // run_end
);

   import bsmooth_pkg::*;

   localparam int AW = $clog2(MAX_FRAME);
   localparam int NW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   frame_ff, frame_in;
   logic [NW-1:0]      eff_n;
   logic [AW-1:0]      row_ff, row_in, col_ff, col_in;
   logic [AW-1:0]      item_row_ff, item_row_in, item_col_ff, item_col_in;
   logic               r1_ff, r1_in, r2_ff, r2_in, c1_ff, c1_in, c2_ff, c2_in;
   logic [3:0]         pend_ff, pend_in;
   pixel_type          px_ff, px_in;
   pixel_type          win_ff [3][3];
   pixel_type          win_in [3][3];
   sum_type            acc_ff, acc_in;
   logic [1:0]         nr_ff, nr_in, nc_ff, nc_in;
   logic [AW-1:0]      res_row_ff, res_row_in, res_col_ff, res_col_in;
   logic               res_last_ff, res_last_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_last_ff, out_last_in;
   logic [COORD_W-1:0] out_row_ff, out_row_in, out_col_ff, out_col_in;
   pixel_type          out_pix_ff, out_pix_in;

   logic               last_row, last_col;
   logic               i_prev, j_prev;
   logic [2:0]         row_mask, col_mask;
   sum_type            win_sum;
   logic               ram_we;
   logic [2*PIX_W-1:0] ram_wdata, ram_rdata;
   pixel_type          older_rd, prev_rd;

   bsmooth_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_FRAME)
   ) u_lines (
      .clock (clock),
      .we    (ram_we),
      .waddr (col_ff),
      .wdata (ram_wdata),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   assign older_rd  = ram_rdata[PIX_W-1:0];
   assign prev_rd   = ram_rdata[2*PIX_W-1:PIX_W];
   assign ram_wdata = {px_ff, prev_rd};
   assign ram_we    = (state_ff == ST_FETCH);

   always_comb begin
      if (frame_ff == '0) begin
         eff_n = NW'(1);
      end else if (NW'(frame_ff) > NW'(MAX_FRAME)) begin
         eff_n = NW'(MAX_FRAME);
      end else begin
         eff_n = NW'(frame_ff);
      end
   end

   assign last_row = (NW'(row_ff) == eff_n - NW'(1));
   assign last_col = (NW'(col_ff) == eff_n - NW'(1));

   // current result: lowest pending bit; bits 0,1 sit one row up, bits 0,2 one column left
   assign i_prev   = pend_ff[0] | pend_ff[1];
   assign j_prev   = pend_ff[0] | (~pend_ff[1] & pend_ff[2]);
   assign row_mask = {1'b1, r1_ff, i_prev & r2_ff};
   assign col_mask = {1'b1, c1_ff, j_prev & c2_ff};

   always_comb begin
      win_sum = '0;
      for (int ri = 0; ri < 3; ri++) begin
         for (int ci = 0; ci < 3; ci++) begin
            if (row_mask[ri] && col_mask[ci]) begin
               win_sum.red   = win_sum.red   + SUM_W'(win_ff[ri][ci].red);
               win_sum.green = win_sum.green + SUM_W'(win_ff[ri][ci].green);
               win_sum.blue  = win_sum.blue  + SUM_W'(win_ff[ri][ci].blue);
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      item_row_in  = item_row_ff;
      item_col_in  = item_col_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      pend_in      = pend_ff;
      px_in        = px_ff;
      win_in       = win_ff;
      acc_in       = acc_ff;
      nr_in        = nr_ff;
      nc_in        = nc_ff;
      res_row_in   = res_row_ff;
      res_col_in   = res_col_ff;
      res_last_in  = res_last_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_last_in  = out_last_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_pix_in   = out_pix_ff;
      req_tready   = (state_ff == ST_IDLE);

      if (csr_we) begin
         frame_in = csr_wdata;
         row_in   = '0;
         col_in   = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               px_in    = req_tdata;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            for (int k = 0; k < 3; k++) begin
               win_in[k][0] = win_ff[k][1];
               win_in[k][1] = win_ff[k][2];
            end
            win_in[0][2] = older_rd;
            win_in[1][2] = prev_rd;
            win_in[2][2] = px_ff;
            item_row_in  = row_ff;
            item_col_in  = col_ff;
            r1_in        = (row_ff != '0);
            r2_in        = (row_ff > AW'(1));
            c1_in        = (col_ff != '0);
            c2_in        = (col_ff > AW'(1));
            pend_in[0]   = (row_ff != '0) & (col_ff != '0);
            pend_in[1]   = (row_ff != '0) & last_col;
            pend_in[2]   = (col_ff != '0) & last_row;
            pend_in[3]   = last_row & last_col;
            if (last_col) begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + AW'(1);
            end else begin
               col_in = col_ff + AW'(1);
            end
            state_in = (pend_in != '0) ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            acc_in      = win_sum;
            nr_in       = {1'b0, row_mask[0]} + {1'b0, row_mask[1]} + {1'b0, row_mask[2]};
            nc_in       = {1'b0, col_mask[0]} + {1'b0, col_mask[1]} + {1'b0, col_mask[2]};
            res_row_in  = item_row_ff - AW'(i_prev);
            res_col_in  = item_col_ff - AW'(j_prev);
            pend_in     = pend_ff & (pend_ff - 4'd1);
            res_last_in = (pend_in == '0);
            state_in    = ST_DIV_ROW;
         end
         ST_DIV_ROW: begin
            acc_in.red   = div_small(acc_ff.red, nr_ff);
            acc_in.green = div_small(acc_ff.green, nr_ff);
            acc_in.blue  = div_small(acc_ff.blue, nr_ff);
            state_in     = ST_DIV_COL;
         end
         ST_DIV_COL: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in     = 1'b1;
               out_last_in      = res_last_ff;
               out_row_in       = COORD_W'(res_row_ff);
               out_col_in       = COORD_W'(res_col_ff);
               out_pix_in.red   = CHAN_W'(div_small(acc_ff.red, nc_ff));
               out_pix_in.green = CHAN_W'(div_small(acc_ff.green, nc_ff));
               out_pix_in.blue  = CHAN_W'(div_small(acc_ff.blue, nc_ff));
               state_in         = (pend_ff != '0) ? ST_SUM : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= FRAME_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_row_ff <= item_row_in;
      item_col_ff <= item_col_in;
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      px_ff       <= px_in;
      win_ff      <= win_in;
      acc_ff      <= acc_in;
      nr_ff       <= nr_in;
      nc_ff       <= nc_in;
      res_row_ff  <= res_row_in;
      res_col_ff  <= res_col_in;
      res_last_ff <= res_last_in;
      out_last_ff <= out_last_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_pix_ff  <= out_pix_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {(RSP_W - 2 * COORD_W - PIX_W)'(0),
                        out_pix_ff.blue, out_pix_ff.green, out_pix_ff.red,
                        out_col_ff, out_row_ff};

endmodule
